// ----- hdl/assert_macros.svh -----
// Assertion macros used by the flow classifier engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ufc_pkg.sv -----
// Types and constants of the UDP flow classifier.
`timescale 1ns / 1ps
package ufc_pkg;

    localparam int KEY_W       = 104;
    localparam int DSCP_W      = 6;
    localparam int DSCP_VALUES = 64;

    localparam logic [7:0]  UDP_PROTOCOL = 8'd17;
    localparam logic [15:0] MIN_PAYLOAD  = 16'd4;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_READ     = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FRAGMENT   = 3'd1;
    localparam logic [2:0] ST_NOT_UDP    = 3'd2;
    localparam logic [2:0] ST_TOO_SHORT  = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;
    localparam logic [2:0] ST_UNKNOWN    = 3'd5;

    // key layout: src, dst, proto, sport, dport
    typedef struct packed {
        logic              op;
        logic [2:0]        pre_status;
        logic [KEY_W-1:0]  key;
        logic [DSCP_W-1:0] dscp;
    } req_t;

    typedef enum logic [2:0] {
        ENG_CLEAR,
        ENG_IDLE,
        ENG_SEARCH,
        ENG_HIST,
        ENG_UPDATE,
        ENG_READ
    } eng_state_t;

endpackage

// ----- hdl/ufc_front.sv -----
// Front end: accepts requests and runs the header checks.
`timescale 1ns / 1ps
module ufc_front #(
    parameter int ID_W = 9
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [12:0]           s_fragment_offset,
    input  logic [7:0]            s_protocol,
    input  logic [31:0]           s_source_address,
    input  logic [31:0]           s_destination_address,
    input  logic [15:0]           s_payload_length,
    input  logic [15:0]           s_source_port,
    input  logic [15:0]           s_destination_port,
    input  logic [5:0]            s_dscp,
    input  logic [ID_W-1:0]       s_query_flow_id,
    input  logic                  q_full,
    input  logic                  clearing,
    output logic                  q_push,
    output ufc_pkg::req_t         q_req,
    output logic [ID_W-1:0]       q_qid
);

    assign s_ready = !q_full && !clearing;
    assign q_push  = s_valid && s_ready;
    assign q_qid   = s_query_flow_id;

    always_comb begin
        q_req.op   = s_operation;
        q_req.dscp = s_dscp;
        q_req.key  = {s_source_address, s_destination_address, s_protocol,
                      s_source_port, s_destination_port};
        if (s_fragment_offset != 13'd0) begin
            q_req.pre_status = ufc_pkg::ST_FRAGMENT;
        end else if (s_protocol != ufc_pkg::UDP_PROTOCOL) begin
            q_req.pre_status = ufc_pkg::ST_NOT_UDP;
        end else if (s_payload_length < ufc_pkg::MIN_PAYLOAD) begin
            q_req.pre_status = ufc_pkg::ST_TOO_SHORT;
        end else begin
            q_req.pre_status = ufc_pkg::ST_OK;
        end
    end

endmodule

// ----- hdl/ufc_fifo.sv -----
// Two-entry request queue between front and engine.
`timescale 1ns / 1ps
module ufc_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              full,
    output logic              empty
);

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/ufc_engine.sv -----
// Back end: flow table search, counters, histogram and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ufc_engine #(
    parameter int MAX_FLOWS   = 256,
    parameter int COUNT_WIDTH = 32,
    parameter int ID_W        = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  ufc_pkg::req_t         q_req,
    input  logic [ID_W-1:0]       q_qid,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [ID_W-1:0]       m_flow_id,
    output logic [31:0]           m_packet_id,
    output logic [31:0]           m_read_source_address,
    output logic [31:0]           m_read_destination_address,
    output logic [7:0]            m_read_protocol,
    output logic [15:0]           m_read_source_port,
    output logic [15:0]           m_read_destination_port,
    output logic [31:0]           m_dscp_count
);

    localparam int SLOT_W     = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int HIST_AW    = SLOT_W + ufc_pkg::DSCP_W;
    localparam int HIST_DEPTH = MAX_FLOWS * ufc_pkg::DSCP_VALUES;
    localparam int KW         = ufc_pkg::KEY_W;

    logic [KW-1:0]          key_mem  [MAX_FLOWS];
    logic [COUNT_WIDTH-1:0] cnt_mem  [MAX_FLOWS];
    logic [COUNT_WIDTH-1:0] hist_mem [HIST_DEPTH];
    logic [KW-1:0]          key_q;
    logic [COUNT_WIDTH-1:0] cnt_q;
    logic [COUNT_WIDTH-1:0] hist_q;

    ufc_pkg::eng_state_t    state_reg, state_next;
    ufc_pkg::req_t          cur_reg, cur_next;
    logic [ID_W-1:0]        qid_reg, qid_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   hit_reg, hit_next;
    logic [COUNT_WIDTH-1:0] pkt_reg, pkt_next;
    logic [SLOT_W-1:0]      scan_reg, scan_next;
    logic [SLOT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [ID_W-1:0]        count_reg, count_next;
    logic [HIST_AW-1:0]     clr_reg, clr_next;

    logic [SLOT_W-1:0]      key_raddr;
    logic [HIST_AW-1:0]     hist_raddr;
    logic                   key_we, cnt_we, hist_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata, hist_wdata;
    logic [HIST_AW-1:0]     hist_waddr;

    logic                   o_set;
    logic [2:0]             o_status;
    logic [ID_W-1:0]        o_flow;
    logic [COUNT_WIDTH-1:0] o_pkt, o_dcnt;
    logic [KW-1:0]          o_key;

    logic                   m_valid_reg;
    logic [2:0]             status_reg;
    logic [ID_W-1:0]        flow_reg;
    logic [COUNT_WIDTH-1:0] pkt_out_reg, dcnt_reg;
    logic [KW-1:0]          key_out_reg;
    logic [63:0]            pkt_wide, dcnt_wide;
    logic [SLOT_W-1:0]      q_slot;

    assign q_slot   = SLOT_W'(q_qid - ID_W'(1));
    assign clearing = (state_reg == ufc_pkg::ENG_CLEAR);

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        qid_next       = qid_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        pkt_next       = pkt_reg;
        scan_next      = scan_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        q_pop          = 1'b0;
        key_raddr      = scan_reg;
        hist_raddr     = {slot_reg, cur_reg.dscp};
        key_we         = 1'b0;
        cnt_we         = 1'b0;
        hist_we        = 1'b0;
        cnt_wdata      = pkt_reg;
        hist_wdata     = hist_q + COUNT_WIDTH'(1);
        hist_waddr     = {slot_reg, cur_reg.dscp};
        o_set          = 1'b0;
        o_status       = ufc_pkg::ST_OK;
        o_flow         = '0;
        o_pkt          = '0;
        o_dcnt         = '0;
        o_key          = '0;
        case (state_reg)
            ufc_pkg::ENG_CLEAR: begin
                hist_we    = 1'b1;
                hist_waddr = clr_reg;
                hist_wdata = '0;
                clr_next   = clr_reg + HIST_AW'(1);
                if (clr_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ufc_pkg::ENG_IDLE;
                end
            end
            ufc_pkg::ENG_IDLE: begin
                key_raddr  = q_slot;
                hist_raddr = {q_slot, q_req.dscp};
                if (!q_empty && !m_valid_reg) begin
                    q_pop    = 1'b1;
                    cur_next = q_req;
                    qid_next = q_qid;
                    if (q_req.op == ufc_pkg::OP_READ) begin
                        if (q_qid == '0 || q_qid > count_reg) begin
                            o_set    = 1'b1;
                            o_status = ufc_pkg::ST_UNKNOWN;
                        end else begin
                            state_next = ufc_pkg::ENG_READ;
                        end
                    end else if (q_req.pre_status != ufc_pkg::ST_OK) begin
                        o_set    = 1'b1;
                        o_status = q_req.pre_status;
                    end else if (count_reg == '0) begin
                        slot_next  = '0;
                        hit_next   = 1'b0;
                        pkt_next   = '0;
                        state_next = ufc_pkg::ENG_HIST;
                    end else begin
                        scan_next      = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = ufc_pkg::ENG_SEARCH;
                    end
                end
            end
            ufc_pkg::ENG_SEARCH: begin
                key_raddr      = scan_reg;
                scan_next      = scan_reg + SLOT_W'(1);
                cmp_idx_next   = scan_reg;
                cmp_valid_next = 1'b1;
                if (cmp_valid_reg && key_q == cur_reg.key) begin
                    slot_next  = cmp_idx_reg;
                    hit_next   = 1'b1;
                    pkt_next   = cnt_q + COUNT_WIDTH'(1);
                    state_next = ufc_pkg::ENG_HIST;
                end else if (cmp_valid_reg &&
                             ID_W'(cmp_idx_reg) + ID_W'(1) == count_reg) begin
                    if (count_reg == ID_W'(MAX_FLOWS)) begin
                        o_set      = 1'b1;
                        o_status   = ufc_pkg::ST_TABLE_FULL;
                        state_next = ufc_pkg::ENG_IDLE;
                    end else begin
                        slot_next  = SLOT_W'(count_reg);
                        hit_next   = 1'b0;
                        pkt_next   = '0;
                        state_next = ufc_pkg::ENG_HIST;
                    end
                end
            end
            ufc_pkg::ENG_HIST: begin
                state_next = ufc_pkg::ENG_UPDATE;
            end
            ufc_pkg::ENG_UPDATE: begin
                hist_we   = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = pkt_reg;
                if (!hit_reg) begin
                    key_we     = 1'b1;
                    count_next = count_reg + ID_W'(1);
                end
                o_set      = 1'b1;
                o_flow     = ID_W'(slot_reg) + ID_W'(1);
                o_pkt      = pkt_reg;
                state_next = ufc_pkg::ENG_IDLE;
            end
            ufc_pkg::ENG_READ: begin
                o_set      = 1'b1;
                o_flow     = qid_reg;
                o_pkt      = cnt_q;
                o_key      = key_q;
                o_dcnt     = hist_q;
                state_next = ufc_pkg::ENG_IDLE;
            end
            default: begin
                state_next = ufc_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ufc_pkg::ENG_CLEAR;
            count_reg     <= '0;
            clr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            cmp_valid_reg <= cmp_valid_next;
            if (o_set) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        qid_reg     <= qid_next;
        slot_reg    <= slot_next;
        hit_reg     <= hit_next;
        pkt_reg     <= pkt_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        if (o_set) begin
            status_reg  <= o_status;
            flow_reg    <= o_flow;
            pkt_out_reg <= o_pkt;
            dcnt_reg    <= o_dcnt;
            key_out_reg <= o_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[slot_reg] <= cur_reg.key;
        end
        key_q <= key_mem[key_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[slot_reg] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[key_raddr];
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q <= hist_mem[hist_raddr];
    end

    assign pkt_wide  = 64'(pkt_out_reg);
    assign dcnt_wide = 64'(dcnt_reg);

    assign m_valid                    = m_valid_reg;
    assign m_status                   = status_reg;
    assign m_flow_id                  = flow_reg;
    assign m_packet_id                = pkt_wide[31:0];
    assign m_dscp_count               = dcnt_wide[31:0];
    assign m_read_source_address      = key_out_reg[103:72];
    assign m_read_destination_address = key_out_reg[71:40];
    assign m_read_protocol            = key_out_reg[39:32];
    assign m_read_source_port         = key_out_reg[31:16];
    assign m_read_destination_port    = key_out_reg[15:0];

    `ASSERT_IMPL(a_no_result_in_clear, aclk, aresetn,
        state_reg == ufc_pkg::ENG_CLEAR, !m_valid_reg, "result during clear")
    `ASSERT_IMPL(a_pop_needs_room, aclk, aresetn,
        q_pop, !m_valid_reg && !q_empty, "pop without output room")
    `ASSERT_IMPL(a_count_bound, aclk, aresetn,
        1'b1, count_reg <= ID_W'(MAX_FLOWS), "flow count over table size")
    `ASSERT_NEXT(a_update_gives_result, aclk, aresetn,
        state_reg == ufc_pkg::ENG_UPDATE, m_valid_reg, "update without result")

endmodule

// ----- hdl/udp_flow_classifier.sv -----
// Top level of the UDP five-tuple flow classifier.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_*: one request per handshake. operation 0 classifies an
//   IPv4 header; operation 1 reads back a flow by query_flow_id and dscp.
//   Result channel m_*: exactly one result per request, in request order.
//   Sequence: rejected or unknown-flow requests finish in the idle state;
//   reads pass through the read state; a classify compares the table keys
//   one entry after another (up to the flows allocated so far), skipping
//   the search while the table is empty, then updates the histogram and
//   counters; a table-full reject ends at the last entry compared.
//   Throughput: one request in the engine at a time; a two-entry queue
//   lets the front accept while the engine works.
//   Reset: after aresetn the histogram memory, MAX_FLOWS * 64 entries
//   (16384 by default), is swept to zero, one entry a cycle; s_ready stays
//   low during the sweep.
//   Stall: a held result blocks the engine; requests queue up to two
//   deep, then s_ready drops.
module udp_flow_classifier #(
    parameter int MAX_FLOWS   = 256,
    parameter int COUNT_WIDTH = 32,
    parameter int ID_W        = 9
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_operation,
    input  logic [12:0]     s_fragment_offset,
    input  logic [7:0]      s_protocol,
    input  logic [31:0]     s_source_address,
    input  logic [31:0]     s_destination_address,
    input  logic [15:0]     s_payload_length,
    input  logic [15:0]     s_source_port,
    input  logic [15:0]     s_destination_port,
    input  logic [5:0]      s_dscp,
    input  logic [ID_W-1:0] s_query_flow_id,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_status,
    output logic [ID_W-1:0] m_flow_id,
    output logic [31:0]     m_packet_id,
    output logic [31:0]     m_read_source_address,
    output logic [31:0]     m_read_destination_address,
    output logic [7:0]      m_read_protocol,
    output logic [15:0]     m_read_source_port,
    output logic [15:0]     m_read_destination_port,
    output logic [31:0]     m_dscp_count
);

    localparam int REQ_W = $bits(ufc_pkg::req_t);

    logic                  q_full, q_empty, q_push, q_pop, clearing;
    ufc_pkg::req_t         f_req, e_req;
    logic [ID_W-1:0]       f_qid, e_qid;
    logic [REQ_W+ID_W-1:0] q_dout;

    ufc_front #(.ID_W(ID_W)) u_front (
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_operation           (s_operation),
        .s_fragment_offset     (s_fragment_offset),
        .s_protocol            (s_protocol),
        .s_source_address      (s_source_address),
        .s_destination_address (s_destination_address),
        .s_payload_length      (s_payload_length),
        .s_source_port         (s_source_port),
        .s_destination_port    (s_destination_port),
        .s_dscp                (s_dscp),
        .s_query_flow_id       (s_query_flow_id),
        .q_full                (q_full),
        .clearing              (clearing),
        .q_push                (q_push),
        .q_req                 (f_req),
        .q_qid                 (f_qid)
    );

    ufc_fifo #(.DATA_W(REQ_W + ID_W)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     ({f_req, f_qid}),
        .pop     (q_pop),
        .dout    (q_dout),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign e_req = ufc_pkg::req_t'(q_dout[REQ_W+ID_W-1:ID_W]);
    assign e_qid = q_dout[ID_W-1:0];

    ufc_engine #(
        .MAX_FLOWS   (MAX_FLOWS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ID_W        (ID_W)
    ) u_engine (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .q_empty                    (q_empty),
        .q_req                      (e_req),
        .q_qid                      (e_qid),
        .q_pop                      (q_pop),
        .clearing                   (clearing),
        .m_valid                    (m_valid),
        .m_ready                    (m_ready),
        .m_status                   (m_status),
        .m_flow_id                  (m_flow_id),
        .m_packet_id                (m_packet_id),
        .m_read_source_address      (m_read_source_address),
        .m_read_destination_address (m_read_destination_address),
        .m_read_protocol            (m_read_protocol),
        .m_read_source_port         (m_read_source_port),
        .m_read_destination_port    (m_read_destination_port),
        .m_dscp_count               (m_dscp_count)
    );

endmodule
